// ===== design/rtu_deframe_pkg.sv =====
// Shared types, codes and helpers for the RTU response deframer.
// Used by rtu_response_deframer_top and the bench; depends on nothing else.
package rtu_deframe_pkg;

  // Largest reply the frame logic accepts, CRC included
  localparam int FRAME_MAX = 256;
  localparam int LEN_LIMIT_I = (FRAME_MAX < 256) ? FRAME_MAX : 256;
  localparam logic [9:0] LEN_LIMIT = 10'(LEN_LIMIT_I);

  // Item operation codes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // End-of-frame status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_TIMEOUT  = 3'd1;
  localparam logic [2:0] ST_BAD_FUNC = 3'd2;
  localparam logic [2:0] ST_TOO_LONG = 3'd3;
  localparam logic [2:0] ST_CRC_ERR  = 3'd4;
  localparam logic [2:0] ST_ID_ERR   = 3'd5;

  // Register map (index of the register in the APB space)
  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic [12:0] TIMEOUT_RESET = 13'd1000;

  // CRC-16 constants (reflected polynomial)
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // Function codes with fixed or counted lengths
  localparam logic [7:0] FC_EXC_BIT = 8'h80;
  localparam logic [7:0] FC_RD_DEV  = 8'h17;
  localparam logic [7:0] FC_WR_MULC = 8'h0F;
  localparam logic [7:0] FC_WR_MULR = 8'h10;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] unit_id;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic       is_end;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [2:0] status;
    logic [7:0] frame_length;
  } result_t;

  // One byte of CRC-16, eight shift steps
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

// ===== design/rtu_response_deframer_top.sv =====
// RTU response deframer: frames one reply, checks CRC and unit id, times out.
// Depends on rtu_deframe_pkg (types, codes, CRC step).

// A start item arms the block with the expected unit id and loads the reply
// deadline from timeout_ticks; byte items are framed by the function code,
// each payload byte comes out with its position and the two CRC bytes are
// held back; one end-of-frame status result closes a frame (ok, timeout,
// unknown function, too long, CRC error, id mismatch) unless a new start item
// abandons it first. An item makes one combinational pass, with an eight-step
// CRC update, into the result or skid register, so one item is accepted each
// cycle while item_stall is low. A two-entry output (result plus skid register)
// keeps input accepted while one result waits; item_stall rises only when both
// entries hold results. Bytes and ticks are ignored while idle.
module rtu_response_deframer_top
  import rtu_deframe_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  output logic         item_stall,
  input  item_t        item,
  output logic         result_valid,
  input  logic         result_stall,
  output result_t      result,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  // Configuration and frame state
  logic [12:0] timeout_ticks;
  logic        busy, busy_next;
  logic [7:0]  expected_id, expected_id_next;
  logic [8:0]  byte_count, byte_count_next;
  logic [8:0]  total_length, total_length_next;
  logic        length_known, length_known_next;
  logic [15:0] crc_accum, crc_accum_next;
  logic [12:0] ticks_left, ticks_left_next;
  logic        id_match, id_match_next;

  // Output stage
  logic        skid_valid;
  result_t     skid;
  logic        res_valid;
  result_t     res;

  logic        accept;
  logic        pop;
  logic [9:0]  idx_plus2;

  assign item_stall = skid_valid;
  assign accept     = item_valid && !item_stall;
  assign pop        = result_valid && !result_stall;
  assign pready     = 1'b1;
  assign prdata     = (paddr[2] == REG_TIMEOUT) ? {19'd0, timeout_ticks} : 32'd0;
  assign idx_plus2  = {1'b0, byte_count} + 10'd2;

  // Write the timeout register
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_TIMEOUT) begin
      timeout_ticks <= pwdata[12:0];
    end
  end

  // Frame logic: next state and the result of one item
  always_comb begin
    busy_next         = busy;
    expected_id_next  = expected_id;
    byte_count_next   = byte_count;
    total_length_next = total_length;
    length_known_next = length_known;
    crc_accum_next    = crc_accum;
    ticks_left_next   = ticks_left;
    id_match_next     = id_match;
    res_valid         = 1'b0;
    res               = '0;

    case (item.op)
      OP_START: begin
        busy_next         = 1'b1;
        expected_id_next  = item.unit_id;
        byte_count_next   = 9'd0;
        total_length_next = 9'd0;
        length_known_next = 1'b0;
        crc_accum_next    = CRC_INIT;
        ticks_left_next   = timeout_ticks;
        id_match_next     = 1'b0;
      end
      OP_TICK: begin
        if (busy) begin
          if (ticks_left <= 13'd1) begin
            ticks_left_next = 13'd0;
            busy_next       = 1'b0;
            res_valid       = 1'b1;
            res.is_end      = 1'b1;
            res.status      = ST_TIMEOUT;
          end else begin
            ticks_left_next = ticks_left - 13'd1;
          end
        end
      end
      OP_BYTE: begin
        if (busy) begin
          byte_count_next = byte_count + 9'd1;
          crc_accum_next  = crc_byte(crc_accum, item.rx_byte);
          res_valid       = 1'b1;

          // Decode the address byte, function code and byte count
          if (byte_count == 9'd0) begin
            id_match_next = (item.rx_byte == expected_id);
          end else if (byte_count == 9'd1) begin
            if ((item.rx_byte & FC_EXC_BIT) != 8'd0) begin
              total_length_next = 9'd5;
              length_known_next = 1'b1;
            end else if ((item.rx_byte >= 8'h01 && item.rx_byte <= 8'h04) ||
                         item.rx_byte == FC_RD_DEV) begin
              length_known_next = 1'b0;
            end else if (item.rx_byte == 8'h05 || item.rx_byte == 8'h06 ||
                         item.rx_byte == FC_WR_MULC || item.rx_byte == FC_WR_MULR) begin
              total_length_next = 9'd8;
              length_known_next = 1'b1;
            end else begin
              res.is_end = 1'b1;
              res.status = ST_BAD_FUNC;
            end
            if (!res.is_end && length_known_next &&
                {1'b0, total_length_next} > LEN_LIMIT) begin
              res.is_end = 1'b1;
              res.status = ST_TOO_LONG;
            end
          end else if (byte_count == 9'd2 && !length_known) begin
            total_length_next = 9'd5 + {1'b0, item.rx_byte};
            length_known_next = 1'b1;
            if ({1'b0, total_length_next} > LEN_LIMIT) begin
              res.is_end = 1'b1;
              res.status = ST_TOO_LONG;
            end
          end

          // Close the frame, hold back CRC bytes, or pass the byte on
          if (!res.is_end) begin
            if (length_known_next && byte_count_next >= total_length_next) begin
              res.is_end = 1'b1;
              if (crc_accum_next != 16'd0) begin
                res.status = ST_CRC_ERR;
              end else if (!id_match_next) begin
                res.status = ST_ID_ERR;
              end else begin
                res.status       = ST_OK;
                res.frame_length = 8'(total_length_next - 9'd2);
              end
            end else if (length_known_next && idx_plus2 >= {1'b0, total_length_next}) begin
              res_valid = 1'b0;
            end else begin
              res.data_byte  = item.rx_byte;
              res.byte_index = byte_count[7:0];
            end
          end
          if (res.is_end) begin
            busy_next = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Hold frame state; advance on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      expected_id  <= 8'd0;
      byte_count   <= 9'd0;
      total_length <= 9'd0;
      length_known <= 1'b0;
      crc_accum    <= CRC_INIT;
      ticks_left   <= 13'd0;
      id_match     <= 1'b0;
    end else if (accept) begin
      busy         <= busy_next;
      expected_id  <= expected_id_next;
      byte_count   <= byte_count_next;
      total_length <= total_length_next;
      length_known <= length_known_next;
      crc_accum    <= crc_accum_next;
      ticks_left   <= ticks_left_next;
      id_match     <= id_match_next;
    end
  end

  // Result register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || pop) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= accept && res_valid;
      end
    end else if (accept && res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || pop) begin
      result <= skid_valid ? skid : res;
    end else if (accept && res_valid) begin
      skid <= res;
    end
  end

  // The skid entry is only used behind a waiting result
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> result_valid)
    else $error("skid entry holds a result while the result register is empty");

  // A status result ends the frame
  assert property (@(posedge clk) disable iff (rst)
    (accept && res_valid && res.is_end) |=> !busy)
    else $error("block still busy after an end-of-frame result");

  // Payload bytes come only from an open frame and keep it open
  assert property (@(posedge clk) disable iff (rst)
    (accept && res_valid && !res.is_end) |=> busy)
    else $error("payload byte emitted outside an open frame");

  // Frame length is reported only with an ok status
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.is_end && result.status != ST_OK) |-> result.frame_length == 8'd0)
    else $error("frame length reported with an error status");

endmodule

// ===== dv/rtu_deframe_tb_pkg.sv =====
// Scoreboard for the RTU response deframer bench: reply framing predictor,
// CRC-16 step and the queue of results still due. Depends on rtu_deframe_pkg.
package rtu_deframe_tb_pkg;
  import rtu_deframe_pkg::*;

  // Longest reply the deframer accepts, CRC included
  localparam int REPLY_LIMIT = (FRAME_MAX < 256) ? FRAME_MAX : 256;

  // Function codes not named in the design package
  localparam logic [7:0] FC_RD_COILS      = 8'h01;
  localparam logic [7:0] FC_RD_HOLD_REGS  = 8'h03;
  localparam logic [7:0] FC_RD_INPUT_REGS = 8'h04;
  localparam logic [7:0] FC_WR_COIL       = 8'h05;
  localparam logic [7:0] FC_WR_REG        = 8'h06;

  // Reflected CRC-16, one octet, least significant bit first
  function automatic logic [15:0] crc16_update(logic [15:0] acc, logic [7:0] octet);
    logic [15:0] a;
    logic        lsb;
    a = acc ^ {8'h00, octet};
    repeat (8) begin
      lsb = a[0];
      a = a >> 1;
      if (lsb) a = a ^ CRC_POLY;
    end
    return a;
  endfunction

  // Read replies whose length comes from the byte count field
  function automatic bit counted_code(logic [7:0] fc);
    return (fc >= FC_RD_COILS && fc <= FC_RD_INPUT_REGS) || fc == FC_RD_DEV;
  endfunction

  // Write echoes of fixed length
  function automatic bit fixed_code(logic [7:0] fc);
    return fc == FC_WR_COIL || fc == FC_WR_REG || fc == FC_WR_MULC || fc == FC_WR_MULR;
  endfunction

  class rtu_reply_scoreboard;
    result_t     pending[$];
    int          errors;
    int          items_seen;
    int          bytes_out;
    int          ends_by_status[8];

    logic [12:0] deadline;
    bit          armed;
    logic [7:0]  want_id;
    logic [8:0]  rx_count;
    logic [8:0]  reply_len;
    bit          len_known;
    logic [15:0] crc;
    logic [12:0] ticks_left;
    bit          id_ok;

    function new();
      deadline   = TIMEOUT_RESET;
      armed      = 1'b0;
      want_id    = '0;
      rx_count   = '0;
      reply_len  = '0;
      len_known  = 1'b0;
      crc        = CRC_INIT;
      ticks_left = '0;
      id_ok      = 1'b0;
      errors     = 0;
      items_seen = 0;
      bytes_out  = 0;
      foreach (ends_by_status[i]) ends_by_status[i] = 0;
    endfunction

    function void set_deadline(logic [12:0] v);
      deadline = v;
    endfunction

    // Close the frame with a status result and go idle
    function void push_end(logic [2:0] st, logic [7:0] len);
      result_t r;
      r = '0;
      r.is_end = 1'b1;
      r.status = st;
      r.frame_length = len;
      pending.push_back(r);
      armed = 1'b0;
    endfunction

    function void push_payload(logic [7:0] octet, logic [7:0] pos);
      result_t r;
      r = '0;
      r.data_byte = octet;
      r.byte_index = pos;
      pending.push_back(r);
    endfunction

    // Advance the frame state by one accepted input transaction
    function void note_item(item_t it);
      logic [8:0] pos;
      bit         closed;
      closed = 1'b0;
      items_seen++;
      case (it.op)
        OP_START: begin
          armed      = 1'b1;
          want_id    = it.unit_id;
          rx_count   = '0;
          reply_len  = '0;
          len_known  = 1'b0;
          crc        = CRC_INIT;
          ticks_left = deadline;
          id_ok      = 1'b0;
        end
        OP_TICK: begin
          if (armed) begin
            if (ticks_left <= 13'd1) begin
              ticks_left = '0;
              push_end(ST_TIMEOUT, 8'd0);
            end else begin
              ticks_left = ticks_left - 13'd1;
            end
          end
        end
        OP_BYTE: begin
          if (armed) begin
            pos = rx_count;
            rx_count = rx_count + 9'd1;
            crc = crc16_update(crc, it.rx_byte);
            if (pos == 9'd0) begin
              id_ok = (it.rx_byte == want_id);
            end else if (pos == 9'd1) begin
              if ((it.rx_byte & FC_EXC_BIT) != 8'h00) begin
                reply_len = 9'd5;
                len_known = 1'b1;
              end else if (counted_code(it.rx_byte)) begin
                len_known = 1'b0;
              end else if (fixed_code(it.rx_byte)) begin
                reply_len = 9'd8;
                len_known = 1'b1;
              end else begin
                push_end(ST_BAD_FUNC, 8'd0);
                closed = 1'b1;
              end
              if (!closed && len_known && int'(reply_len) > REPLY_LIMIT) begin
                push_end(ST_TOO_LONG, 8'd0);
                closed = 1'b1;
              end
            end else if (pos == 9'd2 && !len_known) begin
              reply_len = 9'd5 + {1'b0, it.rx_byte};
              len_known = 1'b1;
              if (int'(reply_len) > REPLY_LIMIT) begin
                push_end(ST_TOO_LONG, 8'd0);
                closed = 1'b1;
              end
            end
            if (!closed) begin
              if (len_known && rx_count >= reply_len) begin
                // CRC first, then the unit id
                if (crc != 16'h0000) push_end(ST_CRC_ERR, 8'd0);
                else if (!id_ok) push_end(ST_ID_ERR, 8'd0);
                else push_end(ST_OK, 8'(reply_len - 9'd2));
              end else if (!(len_known && pos + 9'd2 >= reply_len)) begin
                push_payload(it.rx_byte, pos[7:0]);
              end
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        $error("%s: expected %0d, got %0d", name, want, got);
      end
    endfunction

    // Match one accepted result against the oldest one due
    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        errors++;
        $error("result with none due: is_end %0d status %0d data %0d",
               got.is_end, got.status, got.data_byte);
        return;
      end
      want = pending.pop_front();
      compare_field("is_end", 8'(want.is_end), 8'(got.is_end));
      compare_field("data_byte", want.data_byte, got.data_byte);
      compare_field("byte_index", want.byte_index, got.byte_index);
      compare_field("status", 8'(want.status), 8'(got.status));
      compare_field("frame_length", want.frame_length, got.frame_length);
      if (want.is_end) ends_by_status[want.status]++;
      else bytes_out++;
    endfunction
  endclass

endpackage

// ===== dv/tb.sv =====
// Bench top for rtu_response_deframer_top: drives reply frames, ticks and
// deadline writes, checks every result. Depends on rtu_deframe_pkg and rtu_deframe_tb_pkg.
module tb;
  import rtu_deframe_pkg::*;
  import rtu_deframe_tb_pkg::*;

  typedef enum int {FAULT_NONE, FAULT_BIT_FLIP, FAULT_WRONG_ID, FAULT_CUT} reply_fault_e;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam logic [2:0] TIMEOUT_ADDR = {REG_TIMEOUT, 2'b00};
  localparam logic [7:0] FC_UNKNOWN   = 8'h00;
  localparam int LONG_HOLD_CYCLES     = 80;
  localparam int PHASE_ITEMS          = 60;
  localparam int PRESSURE_PHASE       = 3;

  logic        clk = 1'b0;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  item_t       item;
  logic        result_valid;
  logic        result_stall;
  result_t     result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  rtu_reply_scoreboard sb;
  bit          calm;
  bit          hold_long;
  int          sent;
  int          reg_errors;
  logic [7:0]  frame_buf[$];
  logic [31:0] deadline_list[7] = '{32'd0, 32'd1, 32'd3, 32'd100, 32'd40, 32'd5000,
                                    32'hFFFF_FFFF};

  rtu_response_deframer_top dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Note each accepted transaction on both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) sb.note_item(item);
      if (result_valid && !result_stall) sb.check_result(result);
    end
  end

  // Result side: random stalls, one long hold-off on request
  initial begin
    int n;
    result_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_long) begin
        hold_long = 1'b0;
        n = LONG_HOLD_CYCLES;
      end else begin
        n = calm ? 0 : $urandom_range(0, 7);
      end
      if (n > 0) begin
        result_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      result_stall <= 1'b0;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
    end
  end

  // Offer one transaction after a random gap and hold it until taken
  task automatic send_item(logic [1:0] op, logic [7:0] uid, logic [7:0] octet);
    item_t it;
    int    gap;
    it.op = op;
    it.unit_id = uid;
    it.rx_byte = octet;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sent++;
  endtask

  // Build a reply with a valid CRC, damage it as asked, and send it after a start
  task automatic send_reply(logic [7:0] uid, logic [7:0] fc, int count, reply_fault_e fault);
    logic [15:0] c;
    logic [7:0]  id_on_wire;
    int          keep;
    int          k;
    id_on_wire = (fault == FAULT_WRONG_ID) ? uid ^ 8'($urandom_range(1, 255)) : uid;
    frame_buf.delete();
    frame_buf.push_back(id_on_wire);
    frame_buf.push_back(fc);
    if ((fc & FC_EXC_BIT) != 8'h00) begin
      frame_buf.push_back(8'($urandom));
    end else if (counted_code(fc)) begin
      frame_buf.push_back(8'(count));
      if (count + 5 <= REPLY_LIMIT) repeat (count) frame_buf.push_back(8'($urandom));
    end else if (fixed_code(fc)) begin
      repeat (4) frame_buf.push_back(8'($urandom));
    end
    c = CRC_INIT;
    foreach (frame_buf[i]) c = crc16_update(c, frame_buf[i]);
    frame_buf.push_back(c[7:0]);
    frame_buf.push_back(c[15:8]);
    if (fault == FAULT_BIT_FLIP) begin
      k = $urandom_range(0, frame_buf.size() - 1);
      frame_buf[k] = frame_buf[k] ^ (8'd1 << $urandom_range(0, 7));
    end
    keep = frame_buf.size();
    if (fault == FAULT_CUT) keep = keep - $urandom_range(1, 3);
    send_item(OP_START, uid, 8'($urandom));
    for (k = 0; k < keep; k++) begin
      if ($urandom_range(0, 11) == 0) send_item(OP_TICK, 8'($urandom), 8'($urandom));
      send_item(OP_BYTE, 8'($urandom), frame_buf[k]);
    end
  endtask

  // Random items of any op, stray starts included
  task automatic send_noise(int n);
    repeat (n) send_item(2'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic send_random_frame();
    int           pick;
    int           count;
    logic [7:0]   fc;
    reply_fault_e fault;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      fc = ($urandom_range(0, 4) == 0) ? FC_RD_DEV : FC_RD_COILS + 8'($urandom_range(0, 3));
    end else if (pick < 70) begin
      case ($urandom_range(0, 3))
        0: fc = FC_WR_COIL;
        1: fc = FC_WR_REG;
        2: fc = FC_WR_MULC;
        default: fc = FC_WR_MULR;
      endcase
    end else if (pick < 85) begin
      fc = FC_EXC_BIT | 8'($urandom_range(0, 127));
    end else begin
      fc = 8'($urandom);
    end
    pick = $urandom_range(0, 99);
    if (pick < 3) count = $urandom_range(200, 251);
    else if (pick < 7) count = $urandom_range(252, 255);
    else count = $urandom_range(0, 12);
    pick = $urandom_range(0, 99);
    if (pick < 10) fault = FAULT_BIT_FLIP;
    else if (pick < 18) fault = FAULT_WRONG_ID;
    else if (pick < 25) fault = FAULT_CUT;
    else fault = FAULT_NONE;
    send_reply(8'($urandom), fc, count, fault);
    if ($urandom_range(0, 3) == 0) send_noise($urandom_range(1, 6));
  endtask

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reg_read_check(logic [2:0] addr, logic [12:0] want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[12:0] !== want) begin
      reg_errors++;
      $error("timeout_ticks readback: expected %0d, got %0d", want, prdata[12:0]);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Drop valid and wait until every predicted result has been taken
  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int start_count;
    sb = new();
    calm = 1'b0;
    hold_long = 1'b0;
    sent = 0;
    reg_errors = 0;
    rst <= 1'b1;
    item_valid <= 1'b0;
    item <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: fixed echo, exception, unknown function, count overflow, idle items
    send_reply(8'h00, FC_WR_REG, 0, FAULT_NONE);
    send_reply(8'hFF, FC_EXC_BIT | FC_RD_HOLD_REGS, 0, FAULT_NONE);
    send_reply(8'h5A, FC_UNKNOWN, 0, FAULT_NONE);
    send_reply(8'hA5, FC_RD_HOLD_REGS, 255, FAULT_NONE);
    send_item(OP_TICK, 8'hFF, 8'hFF);
    send_item(OP_UNUSED, 8'h00, 8'h00);

    // Random phases, one deadline setting each
    for (int p = 0; p < 7; p++) begin
      wait_drained();
      reg_write(TIMEOUT_ADDR, deadline_list[p]);
      reg_read_check(TIMEOUT_ADDR, deadline_list[p][12:0]);
      sb.set_deadline(deadline_list[p][12:0]);
      calm = (p == PRESSURE_PHASE);
      if (p == PRESSURE_PHASE) begin
        // Longest legal reply while the result side holds off
        hold_long = 1'b1;
        send_reply(8'($urandom), FC_RD_HOLD_REGS, REPLY_LIMIT - 5, FAULT_NONE);
      end
      start_count = sent;
      while (sent - start_count < PHASE_ITEMS) send_random_frame();
    end
    calm = 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);

    $display("covered %0d input transactions, %0d payload bytes checked, deadlines 0 to 8191",
             sb.items_seen, sb.bytes_out);
    $display("frame ends: ok %0d, timeout %0d, bad function %0d, too long %0d, crc %0d, id %0d",
             sb.ends_by_status[ST_OK], sb.ends_by_status[ST_TIMEOUT],
             sb.ends_by_status[ST_BAD_FUNC], sb.ends_by_status[ST_TOO_LONG],
             sb.ends_by_status[ST_CRC_ERR], sb.ends_by_status[ST_ID_ERR]);
    if (sb.errors == 0 && reg_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run
  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== rtu_response_deframer_top.f =====
design/rtu_deframe_pkg.sv
design/rtu_response_deframer_top.sv
dv/rtu_deframe_tb_pkg.sv
dv/tb.sv
